/* rtl/sine_lfo_interpolated_unit_macros.svh */
// Assertion macros for the sine oscillator block.
// Taken in by the top level; needs nothing else.
`ifndef SINE_LFO_INTERPOLATED_UNIT_MACROS_SVH
`define SINE_LFO_INTERPOLATED_UNIT_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define SLFO_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slfo: same-cycle check failed");

// Consequent in the cycle after the antecedent.
`define SLFO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slfo: next-cycle check failed");

`endif

/* rtl/slfo_pkg.sv */
// Shared types, constants and the quarter-wave sine table of the oscillator.
// No dependencies; every other file of the block but the assertion macros uses it.
package slfo_pkg;

  localparam int unsigned PHASE_W     = 32;
  localparam int unsigned GAIN_W      = 27;
  localparam int unsigned SAMPLE_W    = 28;
  localparam int unsigned IDX_W       = 10;
  localparam int unsigned INDEX_SHIFT = 22;
  localparam int unsigned FRAC_BITS   = 27;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned QDEPTH      = 2;
  localparam int unsigned QPTR_W      = $clog2(QDEPTH);
  localparam int unsigned QCNT_W      = $clog2(QDEPTH + 1);

  localparam logic [GAIN_W-1:0] GAIN_RESET = {GAIN_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_STEP  = 2'd0,
    CFG_GAIN        = 2'd1,
    CFG_START_PHASE = 2'd2
  } cfg_idx_e;

  // One phase word on its way from the front to the back.
  typedef struct packed {
    logic               valid;
    logic [PHASE_W-1:0] phase;
  } q_entry_t;

  typedef longint unsigned u64_t;
  typedef logic [GAIN_W-1:0] qtab_t [256];

  localparam u64_t HALF_PI_Q31 = 64'd3373259426;
  localparam u64_t Q27_MAX     = 64'd134217727;
  localparam u64_t TAYLOR_DIV [10] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
                                       64'd156, 64'd210, 64'd272, 64'd342, 64'd420};

  // sin(pi/2 * r / 256) in Q27, peak 2^27-1, by a Taylor series in Q31
  function automatic u64_t quarter_sine(input int unsigned r);
    u64_t    x;
    u64_t    term;
    u64_t    v;
    longint  sum;
    x = (HALF_PI_Q31 * u64_t'(r) + 64'd128) >> 8;
    term = x;
    sum = longint'(x);
    for (int n = 1; n <= 10; n++) begin
      term = (term * x) >> 31;
      term = (term * x) >> 31;
      term = term / TAYLOR_DIV[n-1];
      if ((n & 1) != 0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = (u64_t'(sum) * Q27_MAX + (64'd1 << 30)) >> 31;
    if (v > Q27_MAX) begin
      v = Q27_MAX;
    end
    return v;
  endfunction

  // Entry t holds the quarter wave at r = t + 1; r = 0 is zero.
  function automatic qtab_t build_qtab();
    qtab_t t;
    for (int r = 1; r <= 256; r++) begin
      t[r-1] = GAIN_W'(quarter_sine(r));
    end
    return t;
  endfunction

  localparam qtab_t QTAB = build_qtab();

  // Full-period entry k, mirrored and negated from the quarter wave.
  function automatic logic signed [SAMPLE_W-1:0] sine_entry(input logic [IDX_W-1:0] k);
    logic [8:0]        m;
    logic [7:0]        ti;
    logic [GAIN_W-1:0] mag;
    m   = k[8] ? (9'd256 - {1'b0, k[7:0]}) : {1'b0, k[7:0]};
    ti  = 8'(m - 9'd1);
    mag = (m == 9'd0) ? '0 : QTAB[ti];
    return k[9] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

endpackage

/* rtl/slfo_if.sv */
// Valid/ready channel interfaces of the oscillator: tick requests in, samples out.
// Depends on slfo_pkg for the sample width.
interface slfo_in_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface slfo_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [slfo_pkg::SAMPLE_W-1:0]  sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

/* rtl/slfo_queue.sv */
// Short phase queue between the tick front end and the sample back end.
// Depends on slfo_pkg.
module slfo_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  slfo_pkg::q_entry_t  push_i,
  input  logic                pop_i,
  output logic                full_o,
  output slfo_pkg::q_entry_t  head_o
);

  logic [slfo_pkg::PHASE_W-1:0] mem_q [slfo_pkg::QDEPTH];
  logic [slfo_pkg::QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [slfo_pkg::QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [slfo_pkg::QCNT_W-1:0]  cnt_q, cnt_d;
  logic                         do_push, do_pop;

  assign full_o       = (cnt_q == slfo_pkg::QCNT_W'(slfo_pkg::QDEPTH));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.phase = mem_q[rd_ptr_q];

  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == slfo_pkg::QPTR_W'(slfo_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == slfo_pkg::QPTR_W'(slfo_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.phase;
    end
  end

endmodule

/* rtl/slfo_front.sv */
// Tick front end: takes requests, owns the phase accumulator, queues the phase to use.
// Depends on slfo_pkg and slfo_if.
module slfo_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  slfo_in_if.sink                       in_chan,
  input  logic [slfo_pkg::PHASE_W-1:0]  phase_step_i,
  input  logic [slfo_pkg::PHASE_W-1:0]  start_phase_i,
  input  logic                          q_full_i,
  output slfo_pkg::q_entry_t            push_o
);

  logic [slfo_pkg::PHASE_W-1:0] phase_q, phase_d;
  logic [slfo_pkg::PHASE_W-1:0] tick_phase;
  logic                         take;

  assign in_chan.ready = !q_full_i;
  assign take          = in_chan.valid && !q_full_i;

  // restart reloads before this tick's sample
  assign tick_phase   = in_chan.restart ? start_phase_i : phase_q;
  assign push_o.valid = take;
  assign push_o.phase = tick_phase;

  // advance modulo 2^32
  assign phase_d = take ? tick_phase + phase_step_i : phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else begin
      phase_q <= phase_d;
    end
  end

endmodule

/* rtl/slfo_back.sv */
// Sample back end: table lookups, interpolation and gain on one shared multiplier,
// then the output register. Depends on slfo_pkg and slfo_if.
module slfo_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  slfo_pkg::q_entry_t           head_i,
  output logic                         pop_o,
  input  logic [slfo_pkg::GAIN_W-1:0]  gain_i,
  slfo_out_if.source                   out_chan
);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_DIFF,
    ST_MUL1,
    ST_ADD,
    ST_MUL2
  } state_e;

  localparam int unsigned SW = slfo_pkg::SAMPLE_W;
  localparam int unsigned PW = 2 * SW + 1;

  state_e                          state_q, state_d;
  logic [slfo_pkg::IDX_W-1:0]      idx_q, idx_d;
  logic [slfo_pkg::FRAC_BITS-1:0]  frac_q, frac_d;
  logic signed [SW-1:0]            y0_q, y0_d;
  logic signed [SW:0]              diff_q, diff_d;
  logic signed [PW-1:0]            prod_q, prod_d;
  logic signed [SW-1:0]            interp_q, interp_d;
  logic signed [SW-1:0]            sample_q, sample_d;
  logic                            out_valid_q, out_valid_d;

  logic [slfo_pkg::IDX_W-1:0]      head_idx;
  logic [slfo_pkg::FRAC_BITS-1:0]  head_frac;
  logic signed [SW-1:0]            y1;
  logic signed [SW:0]              mul_a;
  logic signed [SW-1:0]            mul_b;
  logic signed [PW-1:0]            mul_p;

  assign head_idx  = slfo_pkg::IDX_W'(head_i.phase >> slfo_pkg::INDEX_SHIFT);
  assign head_frac = slfo_pkg::FRAC_BITS'(head_i.phase[slfo_pkg::INDEX_SHIFT-1:0])
                     << (slfo_pkg::FRAC_BITS - slfo_pkg::INDEX_SHIFT);
  assign y1        = slfo_pkg::sine_entry(idx_q + 1'b1);

  // one multiplier: slope times fraction, then interpolated value times gain
  assign mul_a = (state_q == ST_MUL2) ? {interp_q[SW-1], interp_q} : diff_q;
  assign mul_b = (state_q == ST_MUL2) ? $signed({1'b0, gain_i}) : $signed({1'b0, frac_q});
  assign mul_p = mul_a * mul_b;

  assign pop_o           = (state_q == ST_LOAD) && head_i.valid;
  assign out_chan.valid  = out_valid_q;
  assign out_chan.sample = sample_q;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    frac_d      = frac_q;
    y0_d        = y0_q;
    diff_d      = diff_q;
    prod_d      = prod_q;
    interp_d    = interp_q;
    sample_d    = sample_q;
    out_valid_d = out_valid_q && !out_chan.ready;
    unique case (state_q)
      ST_LOAD: begin
        if (head_i.valid) begin
          idx_d   = head_idx;
          frac_d  = head_frac;
          y0_d    = slfo_pkg::sine_entry(head_idx);
          state_d = ST_DIFF;
        end
      end
      ST_DIFF: begin
        diff_d  = {y1[SW-1], y1} - {y0_q[SW-1], y0_q};
        state_d = ST_MUL1;
      end
      ST_MUL1: begin
        prod_d  = mul_p;
        state_d = ST_ADD;
      end
      ST_ADD: begin
        // floor shift by 27, result stays between the two entries
        interp_d = SW'({y0_q[SW-1], y0_q} + prod_q[PW-2:slfo_pkg::FRAC_BITS]);
        state_d  = ST_MUL2;
      end
      ST_MUL2: begin
        // hold until the output register is free
        if (!out_valid_q || out_chan.ready) begin
          sample_d    = mul_p[SW+slfo_pkg::FRAC_BITS-1:slfo_pkg::FRAC_BITS];
          out_valid_d = 1'b1;
          state_d     = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    frac_q   <= frac_d;
    y0_q     <= y0_d;
    diff_q   <= diff_d;
    prod_q   <= prod_d;
    interp_q <= interp_d;
    sample_q <= sample_d;
  end

endmodule

/* rtl/sine_lfo_interpolated_unit.sv */
// A tick taken by the front end queues its phase; the back end pops it in ST_LOAD,
// then passes ST_DIFF, ST_MUL1, ST_ADD and ST_MUL2 and registers the sample. It
// works on one phase at a time: two table reads and two products on its single
// multiplier; the two-entry queue takes ticks while a sample waits for the sink.
// Reset: phase 0, phase_step 0, gain 2^27-1, start_phase 0, queue and output empty.
`include "sine_lfo_interpolated_unit_macros.svh"

module sine_lfo_interpolated_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  slfo_in_if.sink                          in_chan,
  slfo_out_if.source                       out_chan,
  input  logic                             cfg_we_i,
  input  logic [slfo_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [slfo_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  logic [slfo_pkg::PHASE_W-1:0] phase_step_q;
  logic [slfo_pkg::GAIN_W-1:0]  gain_q;
  logic [slfo_pkg::PHASE_W-1:0] start_phase_q;

  slfo_pkg::q_entry_t push;
  slfo_pkg::q_entry_t head;
  logic               q_full;
  logic               pop;

  // unused indexes drop the write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q  <= '0;
      gain_q        <= slfo_pkg::GAIN_RESET;
      start_phase_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        slfo_pkg::CFG_PHASE_STEP:  phase_step_q  <= cfg_wdata_i;
        slfo_pkg::CFG_GAIN:        gain_q        <= cfg_wdata_i[slfo_pkg::GAIN_W-1:0];
        slfo_pkg::CFG_START_PHASE: start_phase_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  slfo_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_chan       (in_chan),
    .phase_step_i  (phase_step_q),
    .start_phase_i (start_phase_q),
    .q_full_i      (q_full),
    .push_o        (push)
  );

  slfo_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .full_o (q_full),
    .head_o (head)
  );

  slfo_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .pop_o    (pop),
    .gain_i   (gain_q),
    .out_chan (out_chan)
  );

  `SLFO_ASSERT_SAME(a_no_push_when_full, clk_i, rst_ni, push.valid, !q_full)
  `SLFO_ASSERT_SAME(a_pop_needs_entry, clk_i, rst_ni, pop, head.valid)
  `SLFO_ASSERT_NEXT(a_push_fills_queue, clk_i, rst_ni, push.valid && !pop, head.valid)

endmodule

/* sim/tb_sine_lfo_interpolated_unit.sv */
// Testbench for sine_lfo_interpolated_unit: drives tick requests, writes registers while idle
// and checks every sample against a predictor with its own sine table and phase accumulator.
// Depends on slfo_pkg and the channel interfaces in slfo_if.sv.
`timescale 1ns / 1ps

module tb_sine_lfo_interpolated_unit;

  localparam int unsigned CLK_PERIOD     = 10;
  localparam int unsigned RESET_CYCLES   = 11;
  localparam int unsigned SETTLE_CYCLES  = 10;
  localparam int unsigned QUIET_LIMIT    = 2000;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned SWEEP_PHASES   = 8;
  localparam int unsigned SWEEP_TICKS    = 190;
  localparam int unsigned SINK_HOLD_LEN  = 150;
  localparam int unsigned TAB_DEPTH      = 1 << slfo_pkg::IDX_W;

  localparam logic [slfo_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  localparam longint unsigned HALF_PI_Q31 = 64'd3373259426;
  localparam longint unsigned PEAK_Q27    = 64'd134217727;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                            cfg_we_i;
  logic [slfo_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [slfo_pkg::CFG_DATA_W-1:0] cfg_wdata_i;

  slfo_in_if  tick_ch ();
  slfo_out_if sample_ch ();

  sine_lfo_interpolated_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_chan     (tick_ch),
    .out_chan    (sample_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Oscillator copy kept by the testbench
  logic signed [slfo_pkg::SAMPLE_W-1:0] sine_tab [TAB_DEPTH];
  logic [slfo_pkg::PHASE_W-1:0]         osc_phase;
  logic [slfo_pkg::PHASE_W-1:0]         osc_step;
  logic [slfo_pkg::GAIN_W-1:0]          osc_gain;
  logic [slfo_pkg::PHASE_W-1:0]         osc_start;

  logic signed [slfo_pkg::SAMPLE_W-1:0] pending_samples [$];
  int unsigned mismatch_cnt = 0;
  int unsigned quiet_cycles = 0;
  int unsigned sink_hold_req = 0;
  bit          in_idle_en = 1'b1;
  bit          sink_idle_en = 1'b1;

  // sin(pi/2 * r / 256) in Q27 with peak 2^27-1, Taylor series in unsigned Q31
  function automatic longint unsigned quarter_wave(input int unsigned r);
    longint unsigned x;
    longint unsigned term;
    longint unsigned mag;
    longint          acc;
    x    = (HALF_PI_Q31 * r + 64'd128) >> 8;
    term = x;
    acc  = longint'(x);
    for (int n = 1; n <= 10; n++) begin
      term = (term * x) >> 31;
      term = (term * x) >> 31;
      term = term / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    mag = (64'(acc) * PEAK_Q27 + (64'd1 << 30)) >> 31;
    if (mag > PEAK_Q27) begin
      mag = PEAK_Q27;
    end
    return mag;
  endfunction

  function automatic void lfo_reset();
    longint unsigned qw [257];
    longint          val;
    int unsigned     quad;
    int unsigned     r;
    for (int unsigned k = 0; k <= 256; k++) begin
      qw[k] = quarter_wave(k);
    end
    for (int unsigned k = 0; k < TAB_DEPTH; k++) begin
      quad = k >> 8;
      r    = k & 255;
      val  = longint'(quad[0] ? qw[256 - r] : qw[r]);
      if (quad[1]) begin
        val = -val;
      end
      sine_tab[k] = slfo_pkg::SAMPLE_W'(val);
    end
    osc_phase = '0;
    osc_step  = '0;
    osc_gain  = {slfo_pkg::GAIN_W{1'b1}};
    osc_start = '0;
  endfunction

  // One tick: optional reload, interpolate, scale by gain, then advance the phase
  function automatic logic signed [slfo_pkg::SAMPLE_W-1:0] lfo_next_sample(
    input logic restart_bit
  );
    logic [slfo_pkg::IDX_W-1:0] k;
    logic [slfo_pkg::IDX_W-1:0] k_next;
    longint           y0;
    longint           y1;
    longint           frac;
    longint           interp;
    longint           prod;
    if (restart_bit) begin
      osc_phase = osc_start;
    end
    k      = slfo_pkg::IDX_W'(osc_phase >> slfo_pkg::INDEX_SHIFT);
    k_next = k + 1'b1;
    frac   = longint'({32'h0, osc_phase & ((32'd1 << slfo_pkg::INDEX_SHIFT) - 32'd1)});
    frac   = frac << (slfo_pkg::FRAC_BITS - slfo_pkg::INDEX_SHIFT);
    y0     = longint'(sine_tab[k]);
    y1     = longint'(sine_tab[k_next]);
    interp = y0 + (((y1 - y0) * frac) >>> slfo_pkg::FRAC_BITS);
    prod   = interp * longint'({37'h0, osc_gain});
    osc_phase = osc_phase + osc_step;
    return slfo_pkg::SAMPLE_W'(prod >>> slfo_pkg::FRAC_BITS);
  endfunction

  function automatic int unsigned gap_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      return $urandom_range(1, 2);
    end else if (pick < 95) begin
      return $urandom_range(3, 8);
    end
    return $urandom_range(20, 60);
  endfunction

  task automatic send_tick(input logic restart_bit);
    int unsigned gap;
    gap = 0;
    if (in_idle_en && $urandom_range(0, 99) < 40) begin
      gap = gap_len();
    end
    if (gap > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    tick_ch.valid   <= 1'b1;
    tick_ch.restart <= restart_bit;
    do @(posedge clk_i); while (tick_ch.ready !== 1'b1);
    pending_samples.push_back(lfo_next_sample(restart_bit));
  endtask

  // Drop valid and let the pipeline drain before touching the registers
  task automatic wait_quiet();
    tick_ch.valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [slfo_pkg::CFG_IDX_W-1:0] idx,
                           input logic [slfo_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      slfo_pkg::CFG_PHASE_STEP:  osc_step  = data;
      slfo_pkg::CFG_GAIN:        osc_gain  = data[slfo_pkg::GAIN_W-1:0];
      slfo_pkg::CFG_START_PHASE: osc_start = data;
      default: ;
    endcase
  endtask

  task automatic test_reset_state();
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
  endtask

  // Table wrap from the last entry to the first, both peaks, negative interpolation
  task automatic test_table_edges();
    wait_quiet();
    write_cfg(slfo_pkg::CFG_PHASE_STEP, 32'h0040_0000);
    write_cfg(slfo_pkg::CFG_START_PHASE, 32'hFFFF_FFFF);
    send_tick(1'b1);
    send_tick(1'b0);
    wait_quiet();
    write_cfg(slfo_pkg::CFG_START_PHASE, 32'h4000_0000);
    send_tick(1'b1);
    send_tick(1'b0);
    wait_quiet();
    write_cfg(slfo_pkg::CFG_START_PHASE, 32'hC000_0000);
    send_tick(1'b1);
    wait_quiet();
    write_cfg(slfo_pkg::CFG_START_PHASE, 32'h8020_0001);
    send_tick(1'b1);
    send_tick(1'b0);
  endtask

  task automatic test_register_fields();
    wait_quiet();
    write_cfg(slfo_pkg::CFG_GAIN, 32'h0000_0000);
    send_tick(1'b1);
    wait_quiet();
    write_cfg(slfo_pkg::CFG_GAIN, 32'h0000_0001);
    send_tick(1'b1);
    wait_quiet();
    // bits above the gain width are dropped
    write_cfg(slfo_pkg::CFG_GAIN, 32'hFFFF_FFFF);
    write_cfg(slfo_pkg::CFG_PHASE_STEP, 32'hFFFF_FFFF);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    wait_quiet();
    // writes to the spare index change nothing
    write_cfg(CFG_IDX_SPARE, 32'h1234_5678);
    send_tick(1'b0);
    send_tick(1'b1);
  endtask

  task automatic test_backpressure();
    wait_quiet();
    write_cfg(slfo_pkg::CFG_PHASE_STEP, $urandom());
    in_idle_en = 1'b0;
    sink_hold_req = SINK_HOLD_LEN;
    repeat (2) @(posedge clk_i);
    repeat (24) send_tick($urandom_range(0, 7) == 0);
    in_idle_en = 1'b1;
    wait_quiet();
  endtask

  task automatic test_random_sweeps();
    logic [slfo_pkg::CFG_DATA_W-1:0] step_val;
    logic [slfo_pkg::CFG_DATA_W-1:0] gain_val;
    logic [slfo_pkg::CFG_DATA_W-1:0] start_val;
    for (int unsigned p = 0; p < SWEEP_PHASES; p++) begin
      wait_quiet();
      case ($urandom_range(0, 4))
        0: step_val = $urandom();
        1: step_val = $urandom_range(0, 32'h00FF_FFFF);
        2: step_val = 32'hFFFF_FFFF - $urandom_range(0, 255);
        3: step_val = $urandom() & 32'h03FF_FFFF;
        default: step_val = '0;
      endcase
      case ($urandom_range(0, 3))
        0: gain_val = '0;
        1: gain_val = $urandom() | 32'h07FF_FFFF;
        2: gain_val = $urandom();
        default: gain_val = $urandom_range(1, 255);
      endcase
      case ($urandom_range(0, 3))
        0: start_val = '0;
        1: start_val = 32'hFFFF_FFFF;
        default: start_val = $urandom();
      endcase
      // first sweep pins every register at its top value
      if (p == 0) begin
        step_val  = 32'hFFFF_FFFF;
        gain_val  = 32'hFFFF_FFFF;
        start_val = 32'hFFFF_FFFF;
      end
      write_cfg(slfo_pkg::CFG_PHASE_STEP, step_val);
      write_cfg(slfo_pkg::CFG_GAIN, gain_val);
      write_cfg(slfo_pkg::CFG_START_PHASE, start_val);
      if ($urandom_range(0, 3) == 0) begin
        write_cfg(CFG_IDX_SPARE, $urandom());
      end
      in_idle_en   = (p % 3 != 2);
      sink_idle_en = (p % 4 != 1);
      for (int unsigned i = 0; i < SWEEP_TICKS; i++) begin
        send_tick($urandom_range(0, 99) < 4);
      end
    end
    in_idle_en   = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  // Sample receiver: random stalls plus the long hold-off on request
  initial begin : sink_side
    int unsigned stall_left;
    stall_left = 0;
    sample_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (sink_hold_req > 0) begin
        stall_left    = sink_hold_req;
        sink_hold_req = 0;
      end else if (stall_left == 0 && sink_idle_en && $urandom_range(0, 99) < 25) begin
        stall_left = gap_len();
      end
      if (stall_left > 0) begin
        sample_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        sample_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_samples
    logic signed [slfo_pkg::SAMPLE_W-1:0] want;
    if (rst_ni && sample_ch.valid && sample_ch.ready) begin
      if (pending_samples.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS) begin
          $display("%0t: unexpected sample %0d", $time, sample_ch.sample);
        end
      end else begin
        want = pending_samples.pop_front();
        if (sample_ch.sample !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS) begin
            $display("%0t: sample mismatch: expected %0d, got %0d",
                     $time, want, sample_ch.sample);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((tick_ch.valid && tick_ch.ready) || (sample_ch.valid && sample_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    tick_ch.valid   <= 1'b0;
    tick_ch.restart <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= slfo_pkg::CFG_PHASE_STEP;
    cfg_wdata_i     <= '0;
    rst_ni          <= 1'b0;
    lfo_reset();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_table_edges();
    test_register_fields();
    test_backpressure();
    test_random_sweeps();
    wait_quiet();
    if (mismatch_cnt == 0 && pending_samples.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
